// ----- hdl/kdda_pkg.sv -----
// Shared types, constants and helpers for the key debounce and door alarm block.
package kdda_pkg;

  localparam int DEF_NUM_KEYS       = 3;
  localparam int DEF_DEBOUNCE_TICKS = 5;

  localparam int PIN_KEYS   = 3;
  localparam int KEY_IDX_W  = 2;
  localparam int CNT_W      = 8;
  localparam int TIME_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DOOR_EN      = 2'd0,
    CFG_ALARM_DELAY  = 2'd1,
    CFG_REPEAT_PER   = 2'd2
  } cfg_idx_t;

  localparam logic [TIME_W-1:0] ALARM_DELAY_RST = 16'd1000;
  localparam logic [TIME_W-1:0] REPEAT_PER_RST  = 16'd3000;

  typedef struct packed {
    logic start;
    logic rpt;
    logic active;
  } alarm_stat_t;

  function automatic logic [CNT_W-1:0] sat_inc8(input logic [CNT_W-1:0] v);
    sat_inc8 = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [TIME_W-1:0] sat_inc16(input logic [TIME_W-1:0] v);
    sat_inc16 = (v == {TIME_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

// ----- hdl/kdda_in_if.sv -----
// Input channel: one poll tick word of active-low pins.
interface kdda_in_if;
  logic       valid;
  logic       ready;
  logic       touch_pin_n;
  logic [2:0] key_pins_n;
  logic       door_pin_n;

  modport source(output valid, touch_pin_n, key_pins_n, door_pin_n, input ready);
  modport sink(input valid, touch_pin_n, key_pins_n, door_pin_n, output ready);
endinterface

// ----- hdl/kdda_out_if.sv -----
// Result channel: event word for one poll tick.
interface kdda_out_if;
  logic       valid;
  logic       ready;
  logic       touch_event;
  logic       key_event;
  logic [1:0] key_index;
  logic       alarm_start;
  logic       alarm_repeat;
  logic       alarm_active;

  modport source(output valid, touch_event, key_event, key_index, alarm_start,
                 alarm_repeat, alarm_active, input ready);
  modport sink(input valid, touch_event, key_event, key_index, alarm_start,
               alarm_repeat, alarm_active, output ready);
endinterface

// ----- hdl/kdda_cfg_if.sv -----
// Configuration write channel: register index and data word.
interface kdda_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/kdda_door_alarm.sv -----
// Door left-open alarm: open timer, alarm flag and repeat timer.
module kdda_door_alarm
  import kdda_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              door_open,
  input  logic [TIME_W-1:0] delay,
  input  logic [TIME_W-1:0] period,
  output alarm_stat_t       stat
);

  logic              seen_r, seen_nxt;
  logic              flag_r, flag_nxt;
  logic [TIME_W-1:0] open_time_r, open_time_nxt;
  logic [TIME_W-1:0] rep_time_r, rep_time_nxt;
  logic              start, rpt;

  always_comb begin
    seen_nxt      = seen_r;
    flag_nxt      = flag_r;
    open_time_nxt = open_time_r;
    rep_time_nxt  = rep_time_r;
    start         = 1'b0;
    rpt           = 1'b0;
    if (step) begin
      if (!door_open) begin
        seen_nxt      = 1'b1;
        open_time_nxt = '0;
        flag_nxt      = 1'b0;
        rep_time_nxt  = '0;
      end else begin
        open_time_nxt = sat_inc16(open_time_r);
        if (seen_r && !flag_r && (open_time_nxt > delay)) begin
          flag_nxt     = 1'b1;
          rep_time_nxt = '0;
          start        = 1'b1;
        end
      end
      if (flag_nxt) begin
        rep_time_nxt = sat_inc16(rep_time_nxt);
        if (rep_time_nxt > period) begin
          rep_time_nxt = '0;
          rpt          = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= 1'b0;
      flag_r      <= 1'b0;
      open_time_r <= '0;
      rep_time_r  <= '0;
    end else begin
      seen_r      <= seen_nxt;
      flag_r      <= flag_nxt;
      open_time_r <= open_time_nxt;
      rep_time_r  <= rep_time_nxt;
    end
  end

  assign stat.start  = start;
  assign stat.rpt    = rpt;
  assign stat.active = flag_nxt;

endmodule

// ----- hdl/key_debounce_door_alarm_core.sv -----
// Top: touch/key debouncer, door alarm; one tick word per cycle unless stalled.
//
//   channel | dir | handshake       | word
//   in_if   | in  | valid / ready   | touch_pin_n, key_pins_n, door_pin_n
//   out_if  | out | valid / ready   | touch/key events, key_index, alarm flags
//   cfg_if  | in  | valid / ready   | index, data (door enable, delay, period)
//
// One tick word per clock while ready; its result appears in the next cycle.
// State updates at the accepting edge; the output register decouples the sides,
// so in_if.ready is high whenever the output register is empty or being taken.
// cfg_if.ready is always high. Sync active-low reset sets all but output data.
module key_debounce_door_alarm_core
  import kdda_pkg::*;
#(
  parameter int NUM_KEYS       = DEF_NUM_KEYS,
  parameter int DEBOUNCE_TICKS = DEF_DEBOUNCE_TICKS
)(
  input  logic        clk,
  input  logic        rst_n,
  kdda_in_if.sink     in_if,
  kdda_out_if.source  out_if,
  kdda_cfg_if.sink    cfg_if
);

  localparam int PW = (NUM_KEYS > PIN_KEYS) ? NUM_KEYS : PIN_KEYS;
  localparam logic [CNT_W-1:0] DB_TICKS = CNT_W'(DEBOUNCE_TICKS);

  logic              door_en_r;
  logic [TIME_W-1:0] delay_r, period_r;

  logic              touch_lat_r, touch_lat_nxt;
  logic [CNT_W-1:0]  touch_cnt_r, touch_cnt_nxt;
  logic [CNT_W-1:0]  key_cnt_r [NUM_KEYS];
  logic [CNT_W-1:0]  key_cnt_nxt [NUM_KEYS];
  logic              key_lat_r [NUM_KEYS];
  logic              key_lat_nxt [NUM_KEYS];

  logic                 out_valid_r;
  logic                 touch_ev_r, key_ev_r, a_start_r, a_rep_r, a_act_r;
  logic [KEY_IDX_W-1:0] key_idx_r;

  logic                 step, touch_ev, key_ev, taken;
  logic [KEY_IDX_W-1:0] key_idx;
  logic [PW-1:0]        pins_ext;
  alarm_stat_t          alarm;

  assign step         = in_if.valid && in_if.ready;
  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      door_en_r <= 1'b0;
      delay_r   <= ALARM_DELAY_RST;
      period_r  <= REPEAT_PER_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_DOOR_EN:     door_en_r <= cfg_if.data[0];
        CFG_ALARM_DELAY: delay_r   <= cfg_if.data;
        CFG_REPEAT_PER:  period_r  <= cfg_if.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    touch_cnt_nxt = touch_cnt_r;
    touch_lat_nxt = touch_lat_r;
    touch_ev      = 1'b0;
    if (step) begin
      if (in_if.touch_pin_n) begin
        touch_cnt_nxt = '0;
        touch_lat_nxt = 1'b0;
      end else begin
        touch_cnt_nxt = sat_inc8(touch_cnt_r);
        if (!touch_lat_r && (touch_cnt_nxt >= DB_TICKS)) begin
          touch_lat_nxt = 1'b1;
          touch_cnt_nxt = '0;
          touch_ev      = 1'b1;
        end
      end
    end
  end

  // keys past the pin field read as released
  always_comb begin
    pins_ext      = {PW{1'b1}};
    pins_ext[2:0] = in_if.key_pins_n;
    taken         = 1'b0;
    key_ev        = 1'b0;
    key_idx       = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      key_cnt_nxt[i] = key_cnt_r[i];
      key_lat_nxt[i] = key_lat_r[i];
      if (step && !touch_ev) begin
        if (!pins_ext[i] && !taken) begin
          taken          = 1'b1;
          key_cnt_nxt[i] = sat_inc8(key_cnt_r[i]);
        end else if (key_lat_r[i]) begin
          key_cnt_nxt[i] = '0;
          key_lat_nxt[i] = 1'b0;
        end else if (key_cnt_r[i] >= DB_TICKS) begin
          key_lat_nxt[i] = 1'b1;
          key_cnt_nxt[i] = '0;
          if (!key_ev) begin
            key_ev  = 1'b1;
            key_idx = KEY_IDX_W'(i);
          end
        end
      end
    end
  end

  kdda_door_alarm u_door (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step && !touch_ev && door_en_r),
    .door_open (in_if.door_pin_n),
    .delay     (delay_r),
    .period    (period_r),
    .stat      (alarm)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touch_cnt_r <= '0;
      touch_lat_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        key_cnt_r[i] <= '0;
        key_lat_r[i] <= 1'b0;
      end
    end else begin
      touch_cnt_r <= touch_cnt_nxt;
      touch_lat_r <= touch_lat_nxt;
      for (int i = 0; i < NUM_KEYS; i++) begin
        key_cnt_r[i] <= key_cnt_nxt[i];
        key_lat_r[i] <= key_lat_nxt[i];
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      touch_ev_r <= touch_ev;
      key_ev_r   <= key_ev;
      key_idx_r  <= key_idx;
      a_start_r  <= alarm.start;
      a_rep_r    <= alarm.rpt;
      a_act_r    <= alarm.active;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.touch_event  = touch_ev_r;
  assign out_if.key_event    = key_ev_r;
  assign out_if.key_index    = key_idx_r;
  assign out_if.alarm_start  = a_start_r;
  assign out_if.alarm_repeat = a_rep_r;
  assign out_if.alarm_active = a_act_r;

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the touch/key debouncer and door alarm core.
`timescale 1ns / 100ps

module testbench;
  import kdda_pkg::*;

  localparam int          NKEYS       = DEF_NUM_KEYS;
  localparam int          DEB_TICKS   = DEF_DEBOUNCE_TICKS;
  localparam int          STALL_LEN   = 300;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic       touch_n;
    logic [2:0] keys_n;
    logic       door_n;
  } tick_word_t;

  typedef struct packed {
    logic                 touch_event;
    logic                 key_event;
    logic [KEY_IDX_W-1:0] key_index;
    logic                 alarm_start;
    logic                 alarm_repeat;
    logic                 alarm_active;
  } tick_result_t;

  logic clk;
  logic rst_n;

  kdda_in_if  in_ch();
  kdda_out_if out_ch();
  kdda_cfg_if cfg_ch();

  key_debounce_door_alarm_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // predicted block state and register copy
  logic [CNT_W-1:0]  touch_cnt;
  bit                touch_latch;
  logic [CNT_W-1:0]  key_cnt [NKEYS];
  bit                key_latch [NKEYS];
  bit                closed_seen;
  logic [TIME_W-1:0] open_ticks;
  logic [TIME_W-1:0] tone_ticks;
  bit                alarm_on;
  bit                door_en;
  logic [TIME_W-1:0] delay_lim;
  logic [TIME_W-1:0] period_lim;

  tick_word_t   pending_ticks [$];
  tick_result_t expected_results [$];

  int          idle_in_pct;
  int          idle_out_pct;
  int unsigned stall_req;
  int unsigned stall_seen;
  int          stall_left;
  bit          in_fire;
  bit          door_open_now;
  int unsigned errors;
  int unsigned cycles;
  int unsigned words_seen;
  int unsigned touch_seen;
  int unsigned key_seen;
  int unsigned start_seen;
  int unsigned repeat_seen;
  tick_word_t   drive_word;
  tick_word_t   bus_word;
  tick_result_t want;

  function automatic tick_result_t debounce_tick(input tick_word_t w);
    tick_result_t r;
    bit           taken;
    bit           held;
    r     = '0;
    taken = 1'b0;
    if (w.touch_n) begin
      touch_cnt   = '0;
      touch_latch = 1'b0;
    end else begin
      if (touch_cnt != '1) touch_cnt = touch_cnt + 1'b1;
      if (!touch_latch && touch_cnt >= DEB_TICKS) begin
        touch_latch   = 1'b1;
        touch_cnt     = '0;
        r.touch_event = 1'b1;
      end
    end
    if (!r.touch_event) begin
      if (door_en) begin
        if (!w.door_n) begin
          closed_seen = 1'b1;
          open_ticks  = '0;
          alarm_on    = 1'b0;
          tone_ticks  = '0;
        end else begin
          if (open_ticks != '1) open_ticks = open_ticks + 1'b1;
          if (closed_seen && !alarm_on && open_ticks > delay_lim) begin
            alarm_on      = 1'b1;
            tone_ticks    = '0;
            r.alarm_start = 1'b1;
          end
        end
        if (alarm_on) begin
          if (tone_ticks != '1) tone_ticks = tone_ticks + 1'b1;
          if (tone_ticks > period_lim) begin
            tone_ticks     = '0;
            r.alarm_repeat = 1'b1;
          end
        end
      end
      for (int k = 0; k < NKEYS; k++) begin
        held = 1'b0;
        if (k < PIN_KEYS && !taken) begin
          if (!w.keys_n[k]) begin
            held  = 1'b1;
            taken = 1'b1;
          end
        end
        if (!held) begin
          if (!key_latch[k]) begin
            if (key_cnt[k] >= DEB_TICKS) begin
              key_latch[k] = 1'b1;
              key_cnt[k]   = '0;
              if (!r.key_event) begin
                r.key_event = 1'b1;
                r.key_index = KEY_IDX_W'(k);
              end
            end
          end else begin
            key_cnt[k]   = '0;
            key_latch[k] = 1'b0;
          end
        end else if (key_cnt[k] != '1) begin
          key_cnt[k] = key_cnt[k] + 1'b1;
        end
      end
    end
    r.alarm_active = alarm_on;
    return r;
  endfunction

  task automatic compare_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // monitor: checks results, feeds the predictor, tracks register writes
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Mismatches found");
      $finish;
    end
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    if (!rst_n) begin
      touch_cnt   = '0;
      touch_latch = 1'b0;
      for (int k = 0; k < NKEYS; k++) begin
        key_cnt[k]   = '0;
        key_latch[k] = 1'b0;
      end
      closed_seen = 1'b0;
      open_ticks  = '0;
      tone_ticks  = '0;
      alarm_on    = 1'b0;
      door_en     = 1'b0;
      delay_lim   = ALARM_DELAY_RST;
      period_lim  = REPEAT_PER_RST;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result word with none expected, actual %b", $time,
                   {out_ch.touch_event, out_ch.key_event, out_ch.key_index,
                    out_ch.alarm_start, out_ch.alarm_repeat, out_ch.alarm_active});
          errors++;
        end else begin
          want = expected_results.pop_front();
          compare_field("touch_event", want.touch_event, out_ch.touch_event);
          compare_field("key_event", want.key_event, out_ch.key_event);
          compare_field("key_index", want.key_index, out_ch.key_index);
          compare_field("alarm_start", want.alarm_start, out_ch.alarm_start);
          compare_field("alarm_repeat", want.alarm_repeat, out_ch.alarm_repeat);
          compare_field("alarm_active", want.alarm_active, out_ch.alarm_active);
          words_seen++;
          touch_seen  += want.touch_event;
          key_seen    += want.key_event;
          start_seen  += want.alarm_start;
          repeat_seen += want.alarm_repeat;
        end
      end
      if (in_fire) begin
        bus_word.touch_n = in_ch.touch_pin_n;
        bus_word.keys_n  = in_ch.key_pins_n;
        bus_word.door_n  = in_ch.door_pin_n;
        expected_results.push_back(debounce_tick(bus_word));
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_idx_t'(cfg_ch.index))
          CFG_DOOR_EN:     door_en    = cfg_ch.data[0];
          CFG_ALARM_DELAY: delay_lim  = cfg_ch.data;
          CFG_REPEAT_PER:  period_lim = cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  // tick word driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= idle_in_pct) begin
        drive_word         = pending_ticks.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.touch_pin_n <= drive_word.touch_n;
        in_ch.key_pins_n  <= drive_word.keys_n;
        in_ch.door_pin_n  <= drive_word.door_n;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver with random and long stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_req != stall_seen) begin
      stall_seen = stall_req;
      stall_left = STALL_LEN - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= idle_out_pct);
    end
  end

  task automatic push_ticks(input int n, input logic t, input logic [2:0] k, input logic d);
    tick_word_t w;
    w.touch_n = t;
    w.keys_n  = k;
    w.door_n  = d;
    repeat (n) pending_ticks.push_back(w);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_ticks.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // well-formed presses and door episodes with random content, plus noise
  task automatic gen_random(input int n);
    int          count;
    int          kind;
    int          len;
    int          idx;
    logic [2:0]  keys;
    count = 0;
    while (count < n) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        len  = $urandom_range(1, 9);
        keys = ($urandom_range(99) < 80) ? 3'b111 : 3'($urandom_range(7));
        push_ticks(len, 1'b0, keys, door_open_now);
        push_ticks(1, 1'b1, 3'b111, door_open_now);
        count += len + 1;
      end else if (kind < 60) begin
        idx  = $urandom_range(0, 2);
        len  = $urandom_range(1, 8);
        keys = 3'b111;
        for (int b = idx + 1; b < 3; b++) keys[b] = 1'($urandom_range(1));
        keys[idx] = 1'b0;
        push_ticks(len, ($urandom_range(99) >= 10), keys, door_open_now);
        idx = $urandom_range(1, 2);
        push_ticks(idx, 1'b1, 3'b111, door_open_now);
        count += len + idx;
      end else if (kind < 80) begin
        if (door_open_now) begin
          len = $urandom_range(1, 3);
          push_ticks(len, 1'b1, 3'b111, 1'b0);
          door_open_now = 1'b0;
          count += len;
        end else begin
          door_open_now = 1'b1;
        end
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) push_ticks(1, 1'($urandom_range(1)), 3'($urandom_range(7)),
                                1'($urandom_range(1)));
        count += len;
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.touch_pin_n  = 1'b1;
    in_ch.key_pins_n   = 3'b111;
    in_ch.door_pin_n   = 1'b1;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_DOOR_EN;
    cfg_ch.data        = '0;
    idle_in_pct        = 31;
    idle_out_pct       = 45;
    door_open_now      = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings, door logic off
    push_ticks(2, 1'b1, 3'b111, 1'b1);
    push_ticks(8, 1'b0, 3'b111, 1'b1);      // touch press, then held latched
    push_ticks(1, 1'b1, 3'b111, 1'b1);
    push_ticks(5, 1'b1, 3'b110, 1'b1);      // key 0 report, then latch clear
    push_ticks(2, 1'b1, 3'b111, 1'b1);
    push_ticks(5, 1'b1, 3'b101, 1'b1);      // key 1 pressed again before clear
    push_ticks(1, 1'b1, 3'b111, 1'b1);
    push_ticks(6, 1'b1, 3'b101, 1'b1);
    push_ticks(2, 1'b1, 3'b111, 1'b1);
    push_ticks(2, 1'b1, 3'b011, 1'b0);      // short presses accumulate
    push_ticks(1, 1'b1, 3'b111, 1'b0);
    push_ticks(3, 1'b1, 3'b011, 1'b0);
    push_ticks(2, 1'b1, 3'b111, 1'b0);
    push_ticks(5, 1'b1, 3'b010, 1'b1);      // only lowest low key is held
    push_ticks(2, 1'b1, 3'b111, 1'b1);
    push_ticks(5, 1'b0, 3'b110, 1'b1);      // touch event skips key update
    push_ticks(1, 1'b0, 3'b110, 1'b1);
    push_ticks(2, 1'b0, 3'b111, 1'b1);
    push_ticks(1, 1'b1, 3'b111, 1'b1);
    push_ticks(260, 1'b0, 3'b111, 1'b1);    // counters saturate
    push_ticks(1, 1'b1, 3'b111, 1'b1);
    push_ticks(260, 1'b1, 3'b101, 1'b1);
    push_ticks(2, 1'b1, 3'b111, 1'b1);
    push_ticks(3, 1'b0, 3'b000, 1'b0);
    push_ticks(4, 1'b0, 3'b111, 1'b0);
    push_ticks(1, 1'b1, 3'b111, 1'b1);
    gen_random(30);
    wait_drained();

    write_reg(CFG_DOOR_EN, 16'd1);
    write_reg(CFG_ALARM_DELAY, 16'd3);
    write_reg(CFG_REPEAT_PER, 16'd2);
    push_ticks(6, 1'b1, 3'b111, 1'b1);      // open but never seen closed
    push_ticks(2, 1'b1, 3'b111, 1'b0);
    push_ticks(12, 1'b1, 3'b111, 1'b1);
    door_open_now = 1'b1;
    gen_random(40);
    stall_req++;
    wait_drained();

    idle_in_pct  = 45;
    idle_out_pct = 31;
    write_reg(CFG_ALARM_DELAY, 16'd0);
    write_reg(CFG_REPEAT_PER, 16'd0);
    gen_random(40);
    push_ticks(1, 1'b1, 3'b111, 1'b0);
    push_ticks(4, 1'b1, 3'b111, 1'b1);
    wait_drained();

    // disabled while the alarm is up: it stays frozen
    write_reg(CFG_DOOR_EN, 16'd0);
    door_open_now = 1'b1;
    gen_random(20);
    wait_drained();
    gen_random(20);
    wait_drained();

    idle_in_pct  = 0;
    idle_out_pct = 0;
    write_reg(CFG_DOOR_EN, 16'd1);
    write_reg(CFG_ALARM_DELAY, 16'hFFFF);
    write_reg(CFG_REPEAT_PER, 16'd1);
    push_ticks(1, 1'b1, 3'b111, 1'b0);
    push_ticks(20, 1'b1, 3'b111, 1'b1);
    push_ticks(1, 1'b1, 3'b111, 1'b0);
    wait_drained();

    write_reg(CFG_ALARM_DELAY, 16'd2);
    write_reg(CFG_REPEAT_PER, 16'hFFFF);
    push_ticks(20, 1'b1, 3'b111, 1'b1);
    push_ticks(1, 1'b1, 3'b111, 1'b0);
    wait_drained();

    write_reg(CFG_ALARM_DELAY, 16'd20);
    write_reg(CFG_REPEAT_PER, 16'd7);
    door_open_now = 1'b0;
    gen_random(30);
    wait_drained();
    repeat (10) @(posedge clk);

    $display("Run checked %0d tick words over seven register settings", words_seen);
    $display("Events: %0d touch, %0d key, %0d alarm start, %0d alarm repeat",
             touch_seen, key_seen, start_seen, repeat_seen);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/kdda_pkg.sv
hdl/kdda_in_if.sv
hdl/kdda_out_if.sv
hdl/kdda_cfg_if.sv
hdl/kdda_door_alarm.sv
hdl/key_debounce_door_alarm_core.sv
bench/testbench.sv
